// ===== hw/rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants for the calendar date adder
// Holds the widths, the controller/datapath command and status structs and
// the month length table (fixed lengths, no leap years).
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

	// Width of the year register; the year wraps modulo 2^YEAR_BITS
	localparam int YEAR_BITS = 16;
	// Width of the add counts; counts are taken modulo 2^ADD_BITS
	localparam int ADD_BITS  = 16;

	localparam int FIELD_W = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;

	// Dividend holds (month - 1) + count or (day - 1) + count
	localparam int DIV_W = ADD_BITS + 1;
	// Remainder stays below 365
	localparam int REM_W = 9;

	// Division by a constant as q = (x * RECIP) >> SHIFT; both reciprocals
	// are exact for every dividend below 2^17, which covers DIV_W = 17
	localparam int RECIP_W = 17;
	localparam int PROD_W  = DIV_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MONTHS = RECIP_W'(87382); // ceil(2^20 / 12)
	localparam int                 SHIFT_MONTHS = 20;
	localparam logic [RECIP_W-1:0] RECIP_DAYS   = RECIP_W'(91930); // ceil(2^25 / 365)
	localparam int                 SHIFT_DAYS   = 25;

	localparam logic [DIV_W-1:0] MONTHS_PER_YEAR = DIV_W'(12);
	localparam logic [DIV_W-1:0] DAYS_PER_YEAR   = DIV_W'(365);

	localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);
	localparam logic [DAY_W-1:0]   DAY_MAX  = DAY_W'(31);

	typedef logic [ADD_BITS-1:0]  add_t;
	typedef logic [YEAR_BITS-1:0] year_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;     // latch the request fields
		logic load;        // set the date from the request
		logic add_year;    // add the year count
		logic div_start;   // load a dividend
		logic div_sel_day; // divisor select: 0 months/12, 1 days/365
		logic div_mul;     // multiply the dividend by the reciprocal
		logic div_fix;     // register quotient and remainder
		logic apply_month; // month from remainder, quotient into year
		logic apply_day;   // quotient into year, remainder into walk
		logic walk_step;   // step one month off the remaining days
		logic finish_day;  // day from remaining days
		logic publish;     // copy the date into the output register
	} cda_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic days_zero;   // day count is zero
		logic walk_done;   // remaining days fit in the current month
		logic out_busy;    // output register full and stalled
	} cda_status_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			MONTH_W'(2):  len = DAY_W'(28);
			MONTH_W'(4),
			MONTH_W'(6),
			MONTH_W'(9),
			MONTH_W'(11): len = DAY_W'(30);
			default:      len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/calendar_date_adder.sv =====
// Sequence: a load request passes S_LOAD and S_PUBLISH; an add request passes
// the year add, the month and day divisions, a walk of at most 11 months and
// S_PUBLISH, skipping the day division and walk when the day count is zero;
// S_PUBLISH waits while an earlier result is stalled. One request at a time: the
// next is taken the cycle after the result is registered, while that result may wait.
// Reset: arst_n clears the date to year 0, January 1 and empties the output.
// ----------------------------------------------------------------------------
// calendar_date_adder: calendar date keeper with fixed month lengths
// Loads a date or adds years, months and days to it and returns the date.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_adder
	import cda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               kind,
	input  wire logic [FIELD_W-1:0] year_value,
	input  wire logic [FIELD_W-1:0] month_value,
	input  wire logic [FIELD_W-1:0] day_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      out_year,
	output logic [MONTH_W-1:0]      out_month,
	output logic [DAY_W-1:0]        out_day
);

	cda_cmd_t    cmd;
	cda_status_t status;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.status   (status),
		.cmd      (cmd)
	);

	cda_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.year_value  (year_value),
		.month_value (month_value),
		.day_value   (day_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_year    (out_year),
		.out_month   (out_month),
		.out_day     (out_day)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/cda_datapath.sv =====
// ----------------------------------------------------------------------------
// cda_datapath: date registers, shared divider and output register
// Holds the current date, a reciprocal-multiply divider by 12 or 365, the
// month-walk subtractor and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_datapath
	import cda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cda_cmd_t           cmd,
	output cda_status_t             status,
	input  wire logic [FIELD_W-1:0] year_value,
	input  wire logic [FIELD_W-1:0] month_value,
	input  wire logic [FIELD_W-1:0] day_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      out_year,
	output logic [MONTH_W-1:0]      out_month,
	output logic [DAY_W-1:0]        out_day
);

	logic [FIELD_W-1:0] yv_q, mv_q, dv_q;
	year_t              cur_year_q;
	logic [MONTH_W-1:0] cur_month_q;
	logic [DAY_W-1:0]   cur_day_q;
	logic [DIV_W-1:0]   div_q;
	logic               sel_day_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DIV_W-1:0]   quo_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W-1:0]   rest_q;
	logic               out_valid_q;

	logic [RECIP_W-1:0] recip;
	logic [DIV_W-1:0]   quo_month;
	logic [DIV_W-1:0]   quo_day;
	logic [DIV_W-1:0]   rem_month;
	logic [DIV_W-1:0]   rem_day;
	logic [DAY_W-1:0]   cur_len;
	logic [MONTH_W-1:0] month_clamp;
	logic [DAY_W-1:0]   day_clamp;

	// Divider: quotient from the high product bits, remainder by back-multiply
	assign recip     = sel_day_q ? RECIP_DAYS : RECIP_MONTHS;
	assign quo_month = DIV_W'(prod_q >> SHIFT_MONTHS);
	assign quo_day   = DIV_W'(prod_q >> SHIFT_DAYS);
	assign rem_month = div_q - quo_month * MONTHS_PER_YEAR;
	assign rem_day   = div_q - quo_day * DAYS_PER_YEAR;
	assign cur_len   = month_len(cur_month_q);

	// Load clamps: month to 1..12, day to 1..31
	always_comb begin
		priority if (mv_q == '0) begin
			month_clamp = JANUARY;
		end else if (mv_q > FIELD_W'(DECEMBER)) begin
			month_clamp = DECEMBER;
		end else begin
			month_clamp = mv_q[MONTH_W-1:0];
		end
		priority if (dv_q == '0) begin
			day_clamp = DAY_W'(1);
		end else if (dv_q > FIELD_W'(DAY_MAX)) begin
			day_clamp = DAY_MAX;
		end else begin
			day_clamp = dv_q[DAY_W-1:0];
		end
	end

	assign status.days_zero = (add_t'(dv_q) == '0);
	assign status.walk_done = (rest_q < REM_W'(cur_len));
	assign status.out_busy  = out_valid_q & out_stall;

	// Request capture, divider and walk remainder
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			yv_q <= year_value;
			mv_q <= month_value;
			dv_q <= day_value;
		end
		if (cmd.div_start) begin
			sel_day_q <= cmd.div_sel_day;
			if (cmd.div_sel_day) begin
				div_q <= DIV_W'(cur_day_q - DAY_W'(1)) + DIV_W'(add_t'(dv_q));
			end else begin
				div_q <= DIV_W'(cur_month_q - JANUARY) + DIV_W'(add_t'(mv_q));
			end
		end
		if (cmd.div_mul) begin
			prod_q <= PROD_W'(div_q) * PROD_W'(recip);
		end
		if (cmd.div_fix) begin
			if (sel_day_q) begin
				quo_q <= quo_day;
				rem_q <= REM_W'(rem_day);
			end else begin
				quo_q <= quo_month;
				rem_q <= REM_W'(rem_month);
			end
		end
		if (cmd.apply_day) begin
			rest_q <= rem_q;
		end else if (cmd.walk_step) begin
			rest_q <= rest_q - REM_W'(cur_len);
		end
	end

	// Date registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= '0;
			cur_month_q <= JANUARY;
			cur_day_q   <= DAY_W'(1);
		end else begin
			if (cmd.load) begin
				cur_year_q  <= year_t'(yv_q);
				cur_month_q <= month_clamp;
				cur_day_q   <= day_clamp;
			end
			if (cmd.add_year) begin
				cur_year_q <= cur_year_q + year_t'(add_t'(yv_q));
			end
			if (cmd.apply_month) begin
				cur_month_q <= rem_q[MONTH_W-1:0] + JANUARY;
				cur_year_q  <= cur_year_q + year_t'(quo_q);
			end
			if (cmd.apply_day) begin
				cur_year_q <= cur_year_q + year_t'(quo_q);
			end
			if (cmd.walk_step) begin
				if (cur_month_q == DECEMBER) begin
					cur_month_q <= JANUARY;
					cur_year_q  <= cur_year_q + year_t'(1);
				end else begin
					cur_month_q <= cur_month_q + MONTH_W'(1);
				end
			end
			if (cmd.finish_day) begin
				cur_day_q <= rest_q[DAY_W-1:0] + DAY_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_year  <= FIELD_W'(cur_year_q);
			out_month <= cur_month_q;
			out_day   <= cur_day_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// cda_ctrl: sequencing state machine for the calendar date adder
// Steps a request through load or year add, month division, day division,
// the month walk and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_ctrl
	import cda_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire cda_status_t status,
	output cda_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_ADD_YEAR,
		S_MUL_MONTH,
		S_FIX_MONTH,
		S_APPLY_MONTH,
		S_MUL_DAY,
		S_FIX_DAY,
		S_APPLY_DAY,
		S_WALK,
		S_PUBLISH
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= kind ? S_ADD_YEAR : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_PUBLISH;
				end
				S_ADD_YEAR: begin
					state_q <= S_MUL_MONTH;
				end
				S_MUL_MONTH: begin
					state_q <= S_FIX_MONTH;
				end
				S_FIX_MONTH: begin
					state_q <= S_APPLY_MONTH;
				end
				S_APPLY_MONTH: begin
					state_q <= status.days_zero ? S_PUBLISH : S_MUL_DAY;
				end
				S_MUL_DAY: begin
					state_q <= S_FIX_DAY;
				end
				S_FIX_DAY: begin
					state_q <= S_APPLY_DAY;
				end
				S_APPLY_DAY: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (status.walk_done) begin
						state_q <= S_PUBLISH;
					end
				end
				S_PUBLISH: begin
					if (!status.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath commands
	always_comb begin
		cmd             = '0;
		cmd.capture     = (state_q == S_IDLE) && in_valid;
		cmd.load        = (state_q == S_LOAD);
		cmd.add_year    = (state_q == S_ADD_YEAR);
		cmd.div_start   = (state_q == S_ADD_YEAR) ||
		                  ((state_q == S_APPLY_MONTH) && !status.days_zero);
		cmd.div_sel_day = (state_q == S_APPLY_MONTH);
		cmd.div_mul     = (state_q == S_MUL_MONTH) || (state_q == S_MUL_DAY);
		cmd.div_fix     = (state_q == S_FIX_MONTH) || (state_q == S_FIX_DAY);
		cmd.apply_month = (state_q == S_APPLY_MONTH);
		cmd.apply_day   = (state_q == S_APPLY_DAY);
		cmd.walk_step   = (state_q == S_WALK) && !status.walk_done;
		cmd.finish_day  = (state_q == S_WALK) && status.walk_done;
		cmd.publish     = (state_q == S_PUBLISH) && !status.out_busy;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cda_checker.sv =====
// ----------------------------------------------------------------------------
// cda_checker: port-level checks for the calendar date adder
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_checker
	import cda_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [MONTH_W-1:0] out_month,
	input wire logic [DAY_W-1:0]   out_day
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// One request at a time: the block is busy right after an acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in flight");

	// Results always carry a month between January and December
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_month >= JANUARY) && (out_month <= DECEMBER))
		else $error("month out of range");

	// Results always carry a day between 1 and 31
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_day != '0))
		else $error("day zero in result");

endmodule

bind calendar_date_adder cda_checker u_cda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_month (out_month),
	.out_day   (out_day)
);

`default_nettype wire

// ===== sim/cda_date_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_date_checker: scoreboard for the calendar date adder
// Watches both channels, keeps its own copy of the calendar date, works out
// the date that each accepted request should return and compares every
// returned date field by field, oldest first.
// ----------------------------------------------------------------------------

package cda_tb_pkg;
	import cda_pkg::*;

	// Request kinds carried on the kind port
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_ADD  = 1'b1
	} date_op_e;

	typedef struct packed {
		logic [FIELD_W-1:0] year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} cal_date_t;
endpackage

module cda_date_checker
	import cda_pkg::*;
	import cda_tb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic               kind,
	input  wire logic [FIELD_W-1:0] year_value,
	input  wire logic [FIELD_W-1:0] month_value,
	input  wire logic [FIELD_W-1:0] day_value,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [FIELD_W-1:0] out_year,
	input  wire logic [MONTH_W-1:0] out_month,
	input  wire logic [DAY_W-1:0]   out_day,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	localparam int unsigned YEAR_DAYS   = 365;
	localparam int unsigned YEAR_MONTHS = 12;

	// Shadow copy of the date held by the block
	year_t              cal_year;
	logic [MONTH_W-1:0] cal_month;
	logic [DAY_W-1:0]   cal_day;

	cal_date_t dates_due[$];
	cal_date_t want;

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
	end

	// Fixed month lengths, no leap years
	function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] m);
		if (m == 2)
			return 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// Apply one request to the shadow date and return the date it answers with
	function automatic cal_date_t next_date(input date_op_e op,
			input logic [FIELD_W-1:0] yv, input logic [FIELD_W-1:0] mv,
			input logic [FIELD_W-1:0] dv);
		int unsigned total;
		int unsigned rest;
		cal_date_t   d;
		if (op == OP_LOAD) begin
			// out-of-range month and day are clamped; an overlong day is kept
			cal_year  = year_t'(yv);
			cal_month = (mv < JANUARY) ? JANUARY :
				(mv > DECEMBER) ? DECEMBER : MONTH_W'(mv);
			cal_day   = (dv == 0) ? DAY_W'(1) : (dv > DAY_MAX) ? DAY_MAX : DAY_W'(dv);
		end else begin
			cal_year = cal_year + year_t'(add_t'(yv));
			// months carry into the year; the day is left alone
			total     = 32'(cal_month) - 1 + 32'(add_t'(mv));
			cal_month = MONTH_W'(total % YEAR_MONTHS + 1);
			cal_year  = cal_year + year_t'(total / YEAR_MONTHS);
			// days: whole years first, then walk month by month
			if (add_t'(dv) != 0) begin
				rest     = 32'(cal_day) - 1 + 32'(add_t'(dv));
				cal_year = cal_year + year_t'(rest / YEAR_DAYS);
				rest     = rest % YEAR_DAYS;
				while (rest >= days_in_month(cal_month)) begin
					rest = rest - days_in_month(cal_month);
					if (cal_month == DECEMBER) begin
						cal_month = JANUARY;
						cal_year  = cal_year + year_t'(1);
					end else begin
						cal_month = cal_month + MONTH_W'(1);
					end
				end
				cal_day = DAY_W'(rest + 1);
			end
		end
		d.year  = FIELD_W'(cal_year);
		d.month = cal_month;
		d.day   = cal_day;
		return d;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
				exp_val, act_val);
		end
	endfunction

	// Result side is checked before the request side of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_year  = '0;
			cal_month = JANUARY;
			cal_day   = DAY_W'(1);
			dates_due.delete();
			pending   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (dates_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual %0d-%0d-%0d",
						$time, out_year, out_month, out_day);
				end else begin
					want = dates_due.pop_front();
					checked++;
					check_field("year", want.year, out_year);
					check_field("month", want.month, out_month);
					check_field("day", want.day, out_day);
				end
			end
			if (in_valid && !in_stall)
				dates_due.push_back(next_date(date_op_e'(kind), year_value,
					month_value, day_value));
			pending = dates_due.size();
		end
	end

endmodule

// ===== sim/calendar_date_adder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_adder_tb: top-level bench for the calendar date adder
// Runs a directed set of loads and adds around the month, year and field
// limits, then three phases of random requests with different idle profiles
// on both sides, including a long output hold. Checking is left to
// cda_date_checker; this module drives requests and reports the verdict.
// ----------------------------------------------------------------------------

module calendar_date_adder_tb;
	import cda_pkg::*;
	import cda_tb_pkg::*;

	localparam int ITEMS_PER_PHASE = 82;
	localparam int HOLD_CYCLES     = 300;
	// extra wait after the queue of expected dates drains
	localparam int DRAIN_CYCLES    = 120;
	// watchdog bound for the roughly 270 requests, with a wide margin
	localparam int CYCLE_LIMIT     = 200000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [FIELD_W-1:0] year_value;
	logic [FIELD_W-1:0] month_value;
	logic [FIELD_W-1:0] day_value;
	logic               out_valid;
	logic               out_stall;
	logic [FIELD_W-1:0] out_year;
	logic [MONTH_W-1:0] out_month;
	logic [DAY_W-1:0]   out_day;

	int errors;
	int pending;
	int checked;

	int          phase;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int          n_loads;
	int          n_adds;
	int          cycle_count;

	calendar_date_adder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.year_value (year_value),
		.month_value(month_value),
		.day_value  (day_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day)
	);

	cda_date_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.year_value (year_value),
		.month_value(month_value),
		.day_value  (day_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timed out with %0d dates outstanding", $time, pending);
		$display("calendar_date_adder_tb: errors");
		$finish;
	end

	// Present one request, idling first at random, and wait for it to be taken
	task automatic offer(input date_op_e op, input logic [FIELD_W-1:0] yv,
			input logic [FIELD_W-1:0] mv, input logic [FIELD_W-1:0] dv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind        = op;
		year_value  = yv;
		month_value = mv;
		day_value   = dv;
		in_valid    = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_LOAD)
			n_loads++;
		else
			n_adds++;
	endtask

	// Mostly small counts, some zero, some over the whole field
	function automatic logic [FIELD_W-1:0] draw_count(input int unsigned small_max);
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0)
			return '0;
		if (r == 1)
			return FIELD_W'($urandom);
		return FIELD_W'($urandom_range(small_max));
	endfunction

	// Output side: random stall, plus one long hold when the last phase opens
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held      = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (phase == 3 && !held) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Request side
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = OP_LOAD;
		year_value     = '0;
		month_value    = '0;
		day_value      = '0;
		phase          = 1;
		send_idle_pct  = 30;
		recv_stall_pct = 52;
		n_loads        = 0;
		n_adds         = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset date, clamping, overlong days, month and year carries
		offer(OP_ADD,  16'd0,     16'd0,     16'd0);
		offer(OP_LOAD, 16'd0,     16'd0,     16'd0);
		offer(OP_LOAD, 16'hFFFF,  16'hFFFF,  16'hFFFF);
		offer(OP_LOAD, 16'd1999,  16'd13,    16'd32);
		offer(OP_LOAD, 16'd2023,  16'd2,     16'd31);
		offer(OP_ADD,  16'd0,     16'd0,     16'd0);
		offer(OP_ADD,  16'd0,     16'd0,     16'd1);
		offer(OP_LOAD, 16'd2023,  16'd1,     16'd31);
		offer(OP_ADD,  16'd0,     16'd1,     16'd0);
		offer(OP_ADD,  16'd0,     16'd11,    16'd0);
		offer(OP_ADD,  16'd0,     16'd12,    16'd0);
		offer(OP_ADD,  16'd0,     16'd13,    16'd0);
		offer(OP_LOAD, 16'd2023,  16'd12,    16'd31);
		offer(OP_ADD,  16'd0,     16'd0,     16'd1);
		offer(OP_ADD,  16'd0,     16'd0,     16'd364);
		offer(OP_ADD,  16'd0,     16'd0,     16'd365);
		offer(OP_ADD,  16'd0,     16'd0,     16'd366);
		offer(OP_LOAD, 16'hFFFF,  16'd12,    16'd31);
		offer(OP_ADD,  16'd0,     16'd0,     16'd1);
		offer(OP_ADD,  16'hFFFF,  16'd0,     16'd0);
		offer(OP_ADD,  16'd0,     16'hFFFF,  16'd0);
		offer(OP_ADD,  16'hFFFF,  16'hFFFF,  16'hFFFF);
		offer(OP_ADD,  16'h8000,  16'h8000,  16'h8000);

		// random: a quarter loads (half of them in range), the rest adds
		for (int p = 1; p <= 3; p++) begin
			case (p)
				1: begin
					send_idle_pct  = 30;
					recv_stall_pct = 52;
				end
				2: begin
					send_idle_pct  = 52;
					recv_stall_pct = 30;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase = p;
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(3) == 0) begin
					if ($urandom_range(1) == 0)
						offer(OP_LOAD, FIELD_W'($urandom), FIELD_W'($urandom_range(1, 12)),
							FIELD_W'($urandom_range(1, 31)));
					else
						offer(OP_LOAD, FIELD_W'($urandom), FIELD_W'($urandom),
							FIELD_W'($urandom));
				end else begin
					offer(OP_ADD, draw_count(5), draw_count(30), draw_count(400));
				end
			end
		end
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("summary: %0d requests (%0d loads, %0d adds), %0d dates compared",
			n_loads + n_adds, n_loads, n_adds, checked);
		$display("summary: three idle profiles and a %0d-cycle output hold", HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("calendar_date_adder_tb: clean");
		else
			$display("calendar_date_adder_tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cda_pkg.sv
hw/rtl/cda_datapath.sv
hw/rtl/cda_ctrl.sv
hw/rtl/calendar_date_adder.sv
hw/rtl/cda_checker.sv
sim/cda_date_checker.sv
sim/calendar_date_adder_tb.sv
